// ----- design/sha256_stream_hash_top_assert.svh -----
// Assertion macros for the SHA-256 stream hash checker.
// Used only by the checker module bound to the top level.
`ifndef SHA256_STREAM_HASH_TOP_ASSERT_SVH
`define SHA256_STREAM_HASH_TOP_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/sha_pkg.sv -----
// Package for the SHA-256 stream hash: payload types, queue entry type,
// round constants and the SHA-256 helper functions. No dependencies.
package sha_pkg;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // One 32-bit big-endian message word handed from the front to the back.
  // blk_end closes a 16-word block; msg_end marks the last block of a message.
  typedef struct packed {
    logic [31:0] word;
    logic        blk_end;
    logic        msg_end;
  } q_entry_t;

  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  localparam logic [31:0] HInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

endpackage

// ----- design/sha_front.sv -----
// Front end: packs message bytes into big-endian words, counts the length and
// generates the padding words. Depends on sha_pkg.
module sha_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sha_pkg::in_item_t in_data,
  output logic              wr_valid,
  output sha_pkg::q_entry_t wr_entry,
  input  logic              wr_full
);

  typedef enum logic [1:0] {S_BYTES, S_PAD, S_LEN_HI, S_LEN_LO} st_t;

  st_t         st_r;
  logic [3:0]  widx_r;      // word position within the block
  logic [1:0]  bidx_r;      // byte position within the word
  logic [23:0] acc_r;       // bytes of the word gathered so far
  logic [60:0] len_r;       // byte count, wraps as the bit length does
  logic        pad_first_r; // first pad word still needs the marker byte

  logic [31:0] word_c;
  logic        take;
  logic [31:0] pad_word;

  assign in_stall = (st_r != S_BYTES) || wr_full;
  assign take     = in_valid && !in_stall;

  always_comb begin
    word_c = '0;
    case (bidx_r)
      2'd0: word_c = {in_data.message_byte, 24'h0};
      2'd1: word_c = {acc_r[23:16], in_data.message_byte, 16'h0};
      2'd2: word_c = {acc_r[23:8], in_data.message_byte, 8'h0};
      2'd3: word_c = {acc_r, in_data.message_byte};
      default: word_c = '0;
    endcase
    pad_word = pad_first_r ? {sha_pkg::PadByte, 24'h0} : 32'h0;
  end

  always_comb begin
    wr_valid = 1'b0;
    wr_entry = '0;
    case (st_r)
      S_BYTES: begin
        // Flush a word when it completes or when the message ends.
        wr_valid          = take && ((bidx_r == 2'd3) || in_data.final_byte);
        wr_entry.word     = word_c;
        if (in_data.final_byte && bidx_r != 2'd3) begin
          wr_entry.word = word_c | ({sha_pkg::PadByte, 24'h0} >> ({3'd0, bidx_r} + 5'd1) * 8);
        end
        wr_entry.blk_end  = (widx_r == 4'd15);
        wr_entry.msg_end  = 1'b0;
      end
      S_PAD: begin
        wr_valid         = 1'b1;
        wr_entry.word    = pad_word;
        wr_entry.blk_end = (widx_r == 4'd15);
      end
      S_LEN_HI: begin
        wr_valid      = 1'b1;
        wr_entry.word = {len_r[60:29]};
      end
      S_LEN_LO: begin
        wr_valid         = 1'b1;
        wr_entry.word    = {len_r[28:0], 3'b000};
        wr_entry.blk_end = 1'b1;
        wr_entry.msg_end = 1'b1;
      end
      default: wr_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_BYTES;
      widx_r      <= '0;
      bidx_r      <= '0;
      len_r       <= '0;
      pad_first_r <= 1'b0;
    end else begin
      case (st_r)
        S_BYTES: begin
          if (take) begin
            acc_r  <= word_c[31:8];
            len_r  <= len_r + 61'd1;
            bidx_r <= bidx_r + 2'd1;
            if (bidx_r == 2'd3 || in_data.final_byte) begin
              widx_r <= widx_r + 4'd1;
              bidx_r <= '0;
            end
            if (in_data.final_byte) begin
              // Marker is already in the flushed word unless that word was full.
              pad_first_r <= (bidx_r == 2'd3);
              if (widx_r == 4'd13 && bidx_r != 2'd3) st_r <= S_LEN_HI;
              else                                   st_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (!wr_full) begin
            pad_first_r <= 1'b0;
            widx_r      <= widx_r + 4'd1;
            if (widx_r == 4'd13) st_r <= S_LEN_HI;
          end
        end
        S_LEN_HI: begin
          if (!wr_full) begin
            widx_r <= widx_r + 4'd1;
            st_r   <= S_LEN_LO;
          end
        end
        S_LEN_LO: begin
          if (!wr_full) begin
            widx_r <= '0;
            len_r  <= '0;
            st_r   <= S_BYTES;
          end
        end
        default: st_r <= S_BYTES;
      endcase
    end
  end

endmodule

// ----- design/sha_queue.sv -----
// Small word queue between the front end and the compression engine.
// Depends on sha_pkg for the entry type and depth.
module sha_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  input  sha_pkg::q_entry_t wr_entry,
  output logic              wr_full,
  output logic              rd_valid,
  output sha_pkg::q_entry_t rd_entry,
  input  logic              rd_take
);

  sha_pkg::q_entry_t            mem_r [sha_pkg::QDepth];
  logic [sha_pkg::QAw-1:0]      wp_r, rp_r;
  logic [sha_pkg::QAw:0]        cnt_r;
  logic                         push, pop;

  assign wr_full  = (cnt_r == (sha_pkg::QAw+1)'(sha_pkg::QDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_entry = mem_r[rp_r];
  assign push     = wr_valid && !wr_full;
  assign pop      = rd_take && rd_valid;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

endmodule

// ----- design/sha_core.sv -----
// Compression engine: one round per cycle over a rolling 16-word schedule,
// chaining update and digest output register. Depends on sha_pkg.
module sha_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_valid,
  input  sha_pkg::q_entry_t  rd_entry,
  output logic               rd_take,
  output logic               out_valid,
  input  logic               out_stall,
  output sha_pkg::out_item_t out_data
);

  typedef enum logic [1:0] {C_LOAD, C_ROUND, C_ADD, C_EMIT} st_t;

  st_t         st_r;
  logic [5:0]  rnd_r;
  logic [3:0]  lw_r;
  logic        last_blk_r;
  logic [31:0] w_r [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [2:0]  oidx_r;

  logic [31:0] wt, t1, t2, ch, mj;

  assign rd_take = (st_r == C_LOAD) && rd_valid;

  always_comb begin
    if (rnd_r < 6'd16) wt = w_r[rnd_r[3:0]];
    else wt = w_r[rnd_r[3:0]] + sha_pkg::ssig0(w_r[rnd_r[3:0] + 4'd1])
            + w_r[rnd_r[3:0] + 4'd9] + sha_pkg::ssig1(w_r[rnd_r[3:0] + 4'd14]);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1 = v_r[7] + sha_pkg::bsig1(v_r[4]) + ch + sha_pkg::RoundK[rnd_r] + wt;
    t2 = sha_pkg::bsig0(v_r[0]) + mj;
  end

  assign out_valid           = (st_r == C_EMIT);
  assign out_data.digest_word = h_r[oidx_r];
  assign out_data.word_index  = oidx_r;
  assign out_data.last_word   = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= C_LOAD;
      lw_r       <= '0;
      rnd_r      <= '0;
      oidx_r     <= '0;
      last_blk_r <= 1'b0;
      for (int k = 0; k < 8; k++) h_r[k] <= sha_pkg::HInit[k];
    end else begin
      case (st_r)
        C_LOAD: begin
          if (rd_valid) begin
            w_r[lw_r] <= rd_entry.word;
            lw_r      <= lw_r + 4'd1;
            if (rd_entry.blk_end) begin
              last_blk_r <= rd_entry.msg_end;
              rnd_r      <= '0;
              for (int k = 0; k < 8; k++) v_r[k] <= h_r[k];
              st_r       <= C_ROUND;
            end
          end
        end
        C_ROUND: begin
          w_r[rnd_r[3:0]] <= wt;
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          rnd_r  <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) st_r <= C_ADD;
        end
        C_ADD: begin
          for (int k = 0; k < 8; k++) h_r[k] <= h_r[k] + v_r[k];
          oidx_r <= '0;
          st_r   <= last_blk_r ? C_EMIT : C_LOAD;
        end
        C_EMIT: begin
          if (!out_stall) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              for (int k = 0; k < 8; k++) h_r[k] <= sha_pkg::HInit[k];
              st_r <= C_LOAD;
            end
          end
        end
        default: st_r <= C_LOAD;
      endcase
    end
  end

endmodule

// ----- design/sha256_stream_hash_top.sv -----
// SHA-256 over a byte stream, one byte per item; a final-flagged byte ends the
// message and yields eight digest words, word 0 first. Bytes are taken one per
// cycle while the four-word queue has room and no padding word is being written;
// they are refused otherwise. The engine loads a block one word per cycle while
// the queue holds words, runs 64 rounds (one round per cycle) and one chaining
// add. While streaming, only four words of the next block wait in the queue
// when loading starts; the other twelve arrive only as their four bytes each
// are taken from the input. The end of a message adds the padding words and
// eight output words.
// Built from sha_front, sha_queue and sha_core; types from sha_pkg.
module sha256_stream_hash_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sha_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sha_pkg::out_item_t out_data
);

  logic              wr_valid, wr_full, rd_valid, rd_take;
  sha_pkg::q_entry_t wr_entry, rd_entry;

  sha_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .wr_valid, .wr_entry, .wr_full);

  sha_queue u_queue (
    .clk, .rst_n, .wr_valid, .wr_entry, .wr_full,
    .rd_valid, .rd_entry, .rd_take);

  sha_core u_core (
    .clk, .rst_n, .rd_valid, .rd_entry, .rd_take,
    .out_valid, .out_stall, .out_data);

endmodule

// ----- design/sha_checker.sv -----
// Port-level checker for the SHA-256 stream hash, bound to the top level.
// Depends on sha_pkg and the assertion macro header.
`include "sha256_stream_hash_top_assert.svh"
module sha_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input sha_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input sha_pkg::out_item_t out_data
);

  `SHA_ASSERT_IMP(a_last_idx, out_valid, out_data.last_word == (out_data.word_index == 3'd7))
  `SHA_ASSERT_NEXT(a_idx_step, out_valid && !out_stall && !out_data.last_word,
    out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
  `SHA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `SHA_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))

endmodule

bind sha256_stream_hash_top sha_checker u_checker (.*);

// ----- dv/tb_sha256_stream_hash_top.sv -----
// Self-checking testbench for the SHA-256 stream hash top level.
// Hashes byte messages in a local SHA-256 predictor and compares each digest word.
// Depends on sha_pkg for the payload types.
`timescale 1ns / 100ps

module tb_sha256_stream_hash_top;

  localparam int StallLimit = 20000;

  localparam logic [31:0] K256 [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  localparam logic [31:0] IvWords [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  sha_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sha_pkg::out_item_t out_data;

  sha256_stream_hash_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // Predictor state.
  logic [31:0] hash_state [8];
  logic [7:0]  blk_bytes [64];
  int          blk_fill;
  logic [63:0] msg_len;

  sha_pkg::in_item_t  byte_items [$];
  sha_pkg::out_item_t digest_expected [$];
  int        fail_count = 0;
  bit        stim_done = 0;
  int        idle_cycles = 0;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K256[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = IvWords[i];
    blk_fill = 0;
    msg_len = '0;
  endtask

  task automatic absorb_byte(sha_pkg::in_item_t it);
    logic [63:0] bits;
    sha_pkg::out_item_t o;
    blk_bytes[blk_fill] = it.message_byte;
    blk_fill++;
    msg_len++;
    if (blk_fill == 64) begin
      hash_block();
      blk_fill = 0;
    end
    if (!it.final_byte) return;
    bits = msg_len << 3;
    blk_bytes[blk_fill++] = 8'h80;
    // Length does not fit behind the pad byte: spill into a fresh block.
    if (blk_fill > 56) begin
      while (blk_fill < 64) blk_bytes[blk_fill++] = 8'h00;
      hash_block();
      blk_fill = 0;
    end
    while (blk_fill < 56) blk_bytes[blk_fill++] = 8'h00;
    for (int k = 0; k < 8; k++) blk_bytes[56+k] = bits[63-8*k -: 8];
    hash_block();
    for (int k = 0; k < 8; k++) begin
      o.digest_word = hash_state[k];
      o.word_index = 3'(k);
      o.last_word = (k == 7);
      digest_expected.push_back(o);
    end
    restart_hash();
  endtask

  task automatic queue_message(int len, int fill_mode);
    sha_pkg::in_item_t it;
    for (int i = 0; i < len; i++) begin
      case (fill_mode)
        0: it.message_byte = 8'h00;
        1: it.message_byte = 8'hff;
        default: it.message_byte = 8'($urandom_range(0, 255));
      endcase
      it.final_byte = (i == len - 1);
      byte_items.push_back(it);
    end
  endtask

  // Driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        absorb_byte(in_data);
        void'(byte_items.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (byte_items.size() > (in_valid && !in_stall ? 0 : 0) &&
                     byte_items.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= byte_items[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: random stretches, each stalling with chance one in three.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (stall_phase <= 0) begin
      stall_phase <= $urandom_range(1, 20);
      out_stall <= ($urandom_range(0, 2) == 0);
    end else begin
      stall_phase <= stall_phase - 1;
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (digest_expected.size() == 0) begin
          $error("digest word with no expectation: %h", out_data.digest_word);
          fail_count++;
        end else begin
          sha_pkg::out_item_t e;
          e = digest_expected.pop_front();
          if (out_data.digest_word !== e.digest_word) begin
            $error("digest_word expected %h actual %h", e.digest_word, out_data.digest_word);
            fail_count++;
          end
          if (out_data.word_index !== e.word_index) begin
            $error("word_index expected %0d actual %0d", e.word_index, out_data.word_index);
            fail_count++;
          end
          if (out_data.last_word !== e.last_word) begin
            $error("last_word expected %0d actual %0d", e.last_word, out_data.last_word);
            fail_count++;
          end
        end
      end
      if (idle_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // The driver uses its own copy of the first item, so the predictor
  // is advanced from the accepted payload, not from the queue head.
  initial begin
    restart_hash();
    // Directed messages: one byte of each extreme, the pad byte spilling the
    // length into a fresh block (56 bytes), final byte filling a block (64 bytes).
    queue_message(1, 0);
    queue_message(1, 1);
    queue_message(56, 1);
    queue_message(64, 2);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (byte_items.size() == 0);
    @(posedge clk);
    while (in_valid) @(posedge clk);
    while (digest_expected.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- sha256_stream_hash_top.f -----
+incdir+design
design/sha_pkg.sv
design/sha_front.sv
design/sha_queue.sv
design/sha_core.sv
design/sha256_stream_hash_top.sv
design/sha_checker.sv
dv/tb_sha256_stream_hash_top.sv
